### hw/rtl/clq_pkg.sv
// Package for the circular linked queue manager: request/response payload types,
// request and status codes, controller state and control/status structs.
// No dependencies.
package clq_pkg;

  localparam int IDX_W     = 4;
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SIZE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LINKED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             elem_present;
    logic [IDX_W-1:0] elem_index;
  } clq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  queue_count;
    logic [IDX_W-1:0]    head_index;
    logic                queue_nonempty;
  } clq_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APP_A,
    S_APP_B,
    S_REM
  } clq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic app_a;
    logic app_b;
    logic rem;
  } clq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_append;
    logic go_remove;
  } clq_stat_t;

endpackage

### hw/rtl/clq_datapath.sv
// Datapath of the circular linked queue manager: link memories, membership
// flags, head/tail/count registers and request classification.
// Depends on clq_pkg.
module clq_datapath #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  clq_pkg::clq_in_t in_req,
  input  clq_pkg::clq_cmd_t cmd,
  output clq_pkg::clq_stat_t stat,
  output clq_pkg::clq_out_t out_rsp
);
  import clq_pkg::*;

  localparam int DEPTH = (POOL_ENTRIES < IDX_SPAN) ? POOL_ENTRIES : IDX_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [AW-1:0] next_mem [DEPTH];
  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_rd_r, prev_rd_r;

  logic [DEPTH-1:0]    member_r, member_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       elem_r;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic          usable;
  logic [AW-1:0] in_idx;
  logic          in_member;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] tail_sel, head_sel;
  logic          nxt_we, prv_we;
  logic [AW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  assign in_idx    = in_req.elem_index[AW-1:0];
  assign usable    = in_req.elem_present && (int'(in_req.elem_index) < POOL_ENTRIES);
  assign in_member = member_r[in_idx];
  assign tail_sel  = head_valid_r ? tail_r : elem_r;
  assign head_sel  = head_valid_r ? head_r : elem_r;
  assign rd_addr   = cmd.capture ? in_idx : elem_r;

  // classify request
  always_comb begin
    stat       = '0;
    status_nxt = ST_OK;
    unique case (in_req.req_type)
      REQ_APPEND: begin
        if (!usable) begin
          status_nxt = ST_NULL;
        end else if (in_member) begin
          status_nxt = ST_LINKED;
        end else begin
          stat.go_append = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!head_valid_r) begin
          status_nxt = ST_EMPTY;
        end else if (!usable) begin
          status_nxt = ST_NULL;
        end else if (!in_member) begin
          status_nxt = ST_MISSING;
        end else begin
          stat.go_remove = 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // link write ports
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = elem_r;
    nxt_wd = elem_r;
    prv_we = 1'b0;
    prv_wa = elem_r;
    prv_wd = elem_r;
    if (cmd.app_a) begin
      nxt_we = 1'b1; nxt_wa = tail_sel; nxt_wd = elem_r;
      prv_we = 1'b1; prv_wa = elem_r;   prv_wd = tail_sel;
    end else if (cmd.app_b) begin
      nxt_we = 1'b1; nxt_wa = elem_r;   nxt_wd = head_sel;
      prv_we = 1'b1; prv_wa = head_sel; prv_wd = elem_r;
    end else if (cmd.rem) begin
      nxt_we = 1'b1; nxt_wa = prev_rd_r; nxt_wd = next_rd_r;
      prv_we = 1'b1; prv_wa = next_rd_r; prv_wd = prev_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    next_rd_r <= next_mem[rd_addr];
    prev_rd_r <= prev_mem[rd_addr];
  end

  // queue bookkeeping
  always_comb begin
    member_nxt     = member_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    head_valid_nxt = head_valid_r;
    count_nxt      = count_r;
    if (cmd.app_b) begin
      member_nxt[elem_r] = 1'b1;
      head_nxt           = head_sel;
      tail_nxt           = elem_r;
      head_valid_nxt     = 1'b1;
      count_nxt          = count_r + CW'(1);
    end else if (cmd.rem) begin
      member_nxt[elem_r] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - CW'(1);
      end
      if (elem_r == tail_r) begin
        tail_nxt = prev_rd_r;
      end
      if (elem_r == head_r) begin
        if (next_rd_r == elem_r) begin
          head_valid_nxt = 1'b0;
          head_nxt       = '0;
          count_nxt      = '0;
        end else begin
          head_nxt = next_rd_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      head_valid_r <= 1'b0;
      count_r      <= '0;
    end else begin
      member_r     <= member_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      head_valid_r <= head_valid_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elem_r   <= in_idx;
      status_r <= status_nxt;
    end
  end

  assign out_rsp.status         = status_r;
  assign out_rsp.queue_count    = COUNT_W'(count_r);
  assign out_rsp.head_index     = head_valid_r ? IDX_W'(head_r) : '0;
  assign out_rsp.queue_nonempty = head_valid_r;

endmodule

### hw/rtl/clq_ctrl.sv
// Controller of the circular linked queue manager: sequences append and
// remove link updates and raises the result strobe. Depends on clq_pkg.
module clq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  clq_pkg::clq_stat_t stat,
  output clq_pkg::clq_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import clq_pkg::*;

  clq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (stat.go_append) begin
            state_nxt = S_APP_A;
          end else if (stat.go_remove) begin
            state_nxt = S_REM;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_APP_A: begin
        cmd.app_a = 1'b1;
        state_nxt = S_APP_B;
      end
      S_APP_B: begin
        cmd.app_b     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REM: begin
        cmd.rem       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/circular_linked_queue_manager.sv
// Top level of the circular linked queue manager: controller plus datapath.
// Depends on clq_pkg, clq_ctrl, clq_datapath.
//
// Usage:
//   A request (in_req) is taken at a rising edge where start is high and
//   busy is low. Exactly one result follows on out_rsp, marked by a
//   one-cycle out_valid strobe; the receiver must take it in that cycle.
//   Steps from the accepting edge to the strobe:
//     size query and any rejected request: strobe register only
//     remove: link read, then link write-back
//     append: two writes to each link memory (one write port each)
//   busy is low again when the result is strobed, so a new request can be taken
//   in the same cycle that a result is strobed.
//   Reset (rst_n low, synchronous) empties the queue: membership flags,
//   head and count clear; link memories need no clearing.
//   There is no output backpressure.
module circular_linked_queue_manager #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  clq_pkg::clq_in_t in_req,
  output logic             out_valid,
  output clq_pkg::clq_out_t out_rsp
);
  import clq_pkg::*;

  clq_cmd_t  cmd;
  clq_stat_t stat;

  clq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  clq_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_rsp (out_rsp)
  );

endmodule

### hw/rtl/clq_checker.sv
// Port-level checker for the circular linked queue manager, bound to the top.
// Depends on clq_pkg and circular_linked_queue_manager.
module clq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input clq_pkg::clq_in_t  in_req,
  input logic              out_valid,
  input clq_pkg::clq_out_t out_rsp
);
  import clq_pkg::*;

  a_nonempty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.queue_nonempty == (out_rsp.queue_count != '0)))
    else $error("nonempty flag disagrees with count");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.queue_nonempty) |-> (out_rsp.head_index == '0))
    else $error("head index nonzero on empty queue");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status <= ST_MISSING))
    else $error("illegal status code");

  a_query_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type != REQ_APPEND && in_req.req_type != REQ_REMOVE)
    |=> (out_valid && out_rsp.status == ST_OK && !busy))
    else $error("size query not answered next cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.queue_count <= COUNT_W'(IDX_SPAN)))
    else $error("count beyond pool");

endmodule

bind circular_linked_queue_manager clq_checker u_clq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
